/* hdl/lprt_pkg.sv */
// ----------------------------------------------------------------------------
// lprt_pkg
// Shared types, codes and helpers for the longest-prefix route table.
// ----------------------------------------------------------------------------
package lprt_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ADDR_BITS         = 32;
  localparam int LEN_BITS          = 6;
  localparam int TAG_BITS          = 8;
  localparam int STAMP_BITS        = 32;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(ADDR_BITS);

  typedef struct packed {
    logic                  valid;
    logic [ADDR_BITS-1:0]  prefix;
    logic [LEN_BITS-1:0]   length;
    logic [TAG_BITS-1:0]   iface;
    logic [ADDR_BITS-1:0]  next_hop;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] len);
    clamp_len = (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  function automatic logic [ADDR_BITS-1:0] len_mask(input logic [LEN_BITS-1:0] len);
    if (len == '0) begin
      len_mask = '0;
    end else if (len >= MAX_LEN) begin
      len_mask = '1;
    end else begin
      len_mask = ~({ADDR_BITS{1'b1}} >> len);
    end
  endfunction

endpackage

/* hdl/lprt_if.sv */
// ----------------------------------------------------------------------------
// lprt_req_if / lprt_rsp_if
// Valid/ready channels for route table requests and responses.
// ----------------------------------------------------------------------------
interface lprt_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic [lprt_pkg::ADDR_BITS-1:0]    address;
  logic [lprt_pkg::LEN_BITS-1:0]     prefix_length;
  logic [lprt_pkg::TAG_BITS-1:0]     iface_tag;
  logic [lprt_pkg::ADDR_BITS-1:0]    next_hop_in;

  modport source (output valid, func, address, prefix_length, iface_tag, next_hop_in,
                  input ready);
  modport sink   (input valid, func, address, prefix_length, iface_tag, next_hop_in,
                  output ready);
endinterface

interface lprt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [lprt_pkg::TAG_BITS-1:0]     out_iface_tag;
  logic [lprt_pkg::ADDR_BITS-1:0]    next_hop_out;
  logic [lprt_pkg::LEN_BITS-1:0]     matched_length;

  modport source (output valid, status, out_iface_tag, next_hop_out, matched_length,
                  input ready);
  modport sink   (input valid, status, out_iface_tag, next_hop_out, matched_length,
                  output ready);
endinterface

/* hdl/lprt_mem.sv */
// ----------------------------------------------------------------------------
// lprt_mem
// Route entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lprt_mem #(
  parameter int DEPTH = lprt_pkg::TABLE_ENTRIES_DEF,
  parameter int IDXW  = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDXW-1:0]      waddr,
  input  lprt_pkg::entry_t     wdata,
  input  logic [IDXW-1:0]      raddr,
  output lprt_pkg::entry_t     rdata
);

  lprt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lprt_ctrl.sv */
// ----------------------------------------------------------------------------
// lprt_ctrl
// Scan sequencer: clears the store after reset, walks all entries per request,
// keeps the best candidate, writes back inserts/deletes, posts the response.
// ----------------------------------------------------------------------------
module lprt_ctrl #(
  parameter int DEPTH = lprt_pkg::TABLE_ENTRIES_DEF,
  parameter int IDXW  = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  lprt_req_if.sink             req,
  lprt_rsp_if.source           rsp,
  output logic                 mem_we,
  output logic [IDXW-1:0]      mem_waddr,
  output lprt_pkg::entry_t     mem_wdata,
  output logic [IDXW-1:0]      mem_raddr,
  input  lprt_pkg::entry_t     mem_rdata
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DEPTH - 1);

  state_t                               state;
  logic [IDXW-1:0]                      rd_idx;
  logic [IDXW-1:0]                      cmp_idx;
  logic                                 rd_pending;
  logic [lprt_pkg::STAMP_BITS-1:0]      insert_counter;

  logic [1:0]                           op_func;
  logic [lprt_pkg::ADDR_BITS-1:0]       op_addr;
  logic [lprt_pkg::LEN_BITS-1:0]        op_len;
  logic [lprt_pkg::TAG_BITS-1:0]        op_tag;
  logic [lprt_pkg::ADDR_BITS-1:0]       op_hop;

  logic                                 best_found;
  logic [IDXW-1:0]                      best_idx;
  logic [lprt_pkg::LEN_BITS-1:0]        best_len;
  logic [lprt_pkg::STAMP_BITS-1:0]      best_stamp;
  logic [lprt_pkg::TAG_BITS-1:0]        best_iface;
  logic [lprt_pkg::ADDR_BITS-1:0]       best_hop;

  logic                                 rsp_valid;
  logic [1:0]                           rsp_status;
  logic [lprt_pkg::TAG_BITS-1:0]        rsp_iface;
  logic [lprt_pkg::ADDR_BITS-1:0]       rsp_hop;
  logic [lprt_pkg::LEN_BITS-1:0]        rsp_len;

  logic                                 slot_free;
  logic                                 lookup_hit;
  logic                                 lookup_better;
  logic                                 lookup_ok;
  logic                                 delete_hit;
  logic                                 delete_better;
  logic                                 take;
  logic                                 finish_fire;
  logic                                 ins_write;
  logic                                 del_write;

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.out_iface_tag  = rsp_iface;
  assign rsp.next_hop_out   = rsp_hop;
  assign rsp.matched_length = rsp_len;

  assign slot_free   = !rsp_valid || rsp.ready;
  assign finish_fire = (state == S_FINISH) && slot_free;
  assign lookup_ok   = (op_func == lprt_pkg::FUNC_LOOKUP) && best_found;

  always_comb begin
    lookup_hit = mem_rdata.valid && (mem_rdata.length != '0) &&
                 (((op_addr ^ mem_rdata.prefix) & lprt_pkg::len_mask(mem_rdata.length)) == '0);
    lookup_better = !best_found || (mem_rdata.length > best_len) ||
                    ((mem_rdata.length == best_len) && (mem_rdata.stamp > best_stamp));
    delete_hit = mem_rdata.valid && (mem_rdata.prefix == op_addr) &&
                 (mem_rdata.length == op_len);
    delete_better = !best_found || (mem_rdata.stamp > best_stamp);
    case (op_func)
      lprt_pkg::FUNC_INSERT: take = !mem_rdata.valid && !best_found;
      lprt_pkg::FUNC_LOOKUP: take = lookup_hit && lookup_better;
      lprt_pkg::FUNC_DELETE: take = delete_hit && delete_better;
      default:               take = 1'b0;
    endcase
  end

  assign ins_write = finish_fire && (op_func == lprt_pkg::FUNC_INSERT) && best_found;
  assign del_write = finish_fire && (op_func == lprt_pkg::FUNC_DELETE) && best_found;

  always_comb begin
    mem_raddr = rd_idx;
    mem_we    = (state == S_CLEAR) || ins_write || del_write;
    mem_waddr = (state == S_CLEAR) ? rd_idx : best_idx;
    mem_wdata = '0;
    if (ins_write) begin
      mem_wdata.valid    = 1'b1;
      mem_wdata.prefix   = op_addr;
      mem_wdata.length   = op_len;
      mem_wdata.iface    = op_tag;
      mem_wdata.next_hop = op_hop;
      mem_wdata.stamp    = insert_counter;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx;
    if (rd_pending && take) begin
      best_idx   <= cmp_idx;
      best_len   <= mem_rdata.length;
      best_stamp <= mem_rdata.stamp;
      best_iface <= mem_rdata.iface;
      best_hop   <= mem_rdata.next_hop;
    end
    if (state == S_IDLE && req.valid) begin
      op_func <= req.func;
      op_addr <= req.address;
      op_len  <= lprt_pkg::clamp_len(req.prefix_length);
      op_tag  <= req.iface_tag;
      op_hop  <= req.next_hop_in;
    end
    if (finish_fire) begin
      rsp_iface <= lookup_ok ? best_iface : '0;
      rsp_hop   <= lookup_ok ? best_hop : '0;
      rsp_len   <= lookup_ok ? best_len : '0;
      case (op_func)
        lprt_pkg::FUNC_INSERT: begin
          rsp_status <= best_found ? lprt_pkg::ST_OK : lprt_pkg::ST_FULL;
        end
        lprt_pkg::FUNC_LOOKUP, lprt_pkg::FUNC_DELETE: begin
          rsp_status <= best_found ? lprt_pkg::ST_OK : lprt_pkg::ST_MISS;
        end
        default: begin
          rsp_status <= lprt_pkg::ST_MISS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      rd_idx         <= '0;
      rd_pending     <= 1'b0;
      insert_counter <= '0;
      rsp_valid      <= 1'b0;
      best_found     <= 1'b0;
    end else begin
      rd_pending <= (state == S_SCAN);
      if (finish_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (rd_pending && take) begin
        best_found <= 1'b1;
      end
      case (state)
        S_CLEAR: begin
          if (rd_idx == LAST_IDX) begin
            rd_idx <= '0;
            state  <= S_IDLE;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            best_found <= 1'b0;
            rd_idx     <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx == LAST_IDX) begin
            rd_idx <= '0;
            state  <= S_DRAIN;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (slot_free) begin
            if (ins_write) begin
              insert_counter <= insert_counter + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DRAIN) |-> !mem_we)
    else $error("table written during scan");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_FINISH))
    else $error("response posted outside finish");

  a_counter_on_insert: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && insert_counter != $past(insert_counter)) |->
      $past(ins_write))
    else $error("insert counter moved without insert");

  a_pending_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> (state == S_SCAN || state == S_DRAIN))
    else $error("read data pending outside scan");

endmodule

/* hdl/longest_prefix_route_table_top.sv */
// ----------------------------------------------------------------------------
// longest_prefix_route_table_top
// IPv4 route table with insert, longest-prefix lookup and delete.
// ----------------------------------------------------------------------------
// Channel   Dir   Payload
// req       in    func, address, prefix_length, iface_tag, next_hop_in
// rsp       out   status, out_iface_tag, next_hop_out, matched_length
//
// Each request walks the whole table: one entry is read from the
// single-port-read table memory per cycle, then a drain state takes the
// last read and a finish state writes back and posts the response.
// After reset a clearing pass over every entry runs; req.ready is low.
// A waiting response does not block the next request's scan; the request
// holds in its finish state until the response register is free.
// ----------------------------------------------------------------------------
module longest_prefix_route_table_top #(
  parameter int TABLE_ENTRIES = lprt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lprt_req_if.sink    req,
  lprt_rsp_if.source  rsp
);

  localparam int IDXW = $clog2(TABLE_ENTRIES);

  logic              mem_we;
  logic [IDXW-1:0]   mem_waddr;
  logic [IDXW-1:0]   mem_raddr;
  lprt_pkg::entry_t  mem_wdata;
  lprt_pkg::entry_t  mem_rdata;

  lprt_ctrl #(
    .DEPTH (TABLE_ENTRIES),
    .IDXW  (IDXW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lprt_mem #(
    .DEPTH (TABLE_ENTRIES),
    .IDXW  (IDXW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the longest-prefix route table. A shadow copy of the table
// predicts the response to every accepted request: insert into the lowest
// free slot, longest-prefix lookup with the newest route winning a tie, and
// exact-match delete of the newest copy. Responses are checked in order,
// field by field. Directed requests cover the length rules, the tie rule and
// the unused code; a capacity pass fills the table past its limit, and
// phased random traffic over a shared route pool follows. The request side
// sends in bursts with random gaps; the response side stalls on its own
// pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import lprt_pkg::*;

  localparam int ENTRIES         = TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT     = 5000;
  localparam int TARGET_REQUESTS = 1350;
  localparam int POOL_SIZE       = 24;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]           func;
    logic [ADDR_BITS-1:0] address;
    logic [LEN_BITS-1:0]  prefix_length;
    logic [TAG_BITS-1:0]  iface_tag;
    logic [ADDR_BITS-1:0] next_hop;
  } route_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [TAG_BITS-1:0]  iface_tag;
    logic [ADDR_BITS-1:0] next_hop;
    logic [LEN_BITS-1:0]  matched_length;
  } route_rsp_t;

  logic clk;
  logic rst;

  lprt_req_if req_ch();
  lprt_rsp_if rsp_ch();

  longest_prefix_route_table_top #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // shadow route table
  logic                  rt_valid [ENTRIES];
  logic [ADDR_BITS-1:0]  rt_prefix[ENTRIES];
  logic [LEN_BITS-1:0]   rt_len   [ENTRIES];
  logic [TAG_BITS-1:0]   rt_tag   [ENTRIES];
  logic [ADDR_BITS-1:0]  rt_hop   [ENTRIES];
  logic [STAMP_BITS-1:0] rt_stamp [ENTRIES];
  logic [STAMP_BITS-1:0] insert_seq;

  route_rsp_t expected_rsp_q[$];
  route_rsp_t exp_rsp;

  logic [ADDR_BITS-1:0] pool_addr[POOL_SIZE];
  logic [LEN_BITS-1:0]  pool_len [POOL_SIZE];

  int mismatches    = 0;
  int requests_sent = 0;
  int idle_cycles   = 0;
  int burst_left    = 0;
  int n_insert = 0, n_full = 0, n_lookup = 0, n_hit = 0;
  int n_delete = 0, n_removed = 0, n_unused = 0;

  logic sink_rdy  = 1'b0;
  int   sink_mode = 0;
  int   sink_seg  = 0;
  int   sink_hold = 0;

  function automatic logic [LEN_BITS-1:0] limit_len(input logic [LEN_BITS-1:0] l);
    return (l > MAX_LEN) ? MAX_LEN : l;
  endfunction

  // len must already be limited to 0..32
  function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [LEN_BITS-1:0] len);
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic route_req_t make_request(input logic [1:0] func,
                                              input logic [ADDR_BITS-1:0] address,
                                              input logic [LEN_BITS-1:0] len,
                                              input logic [TAG_BITS-1:0] tag,
                                              input logic [ADDR_BITS-1:0] hop);
    route_req_t r;
    r.func          = func;
    r.address       = address;
    r.prefix_length = len;
    r.iface_tag     = tag;
    r.next_hop      = hop;
    return r;
  endfunction

  function automatic route_req_t pool_request(input logic [1:0] func, input int k);
    return make_request(func, pool_addr[k], pool_len[k], 8'($urandom), $urandom);
  endfunction

  function automatic int find_live_slot(input int start);
    int slot;
    slot = -1;
    for (int j = 0; j < ENTRIES; j++) begin
      if (slot < 0 && rt_valid[(start + j) % ENTRIES]) slot = (start + j) % ENTRIES;
    end
    return slot;
  endfunction

  // Applies one request to the shadow table and returns its response.
  function automatic route_rsp_t apply_route_op(input route_req_t r);
    route_rsp_t o;
    logic [LEN_BITS-1:0] len;
    int slot;
    o = '0;
    o.status = ST_MISS;
    len = limit_len(r.prefix_length);
    slot = -1;
    case (r.func)
      FUNC_INSERT: begin
        n_insert++;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !rt_valid[i]) slot = i;
        end
        if (slot < 0) begin
          o.status = ST_FULL;
          n_full++;
        end else begin
          rt_valid[slot]  = 1'b1;
          rt_prefix[slot] = r.address;
          rt_len[slot]    = len;
          rt_tag[slot]    = r.iface_tag;
          rt_hop[slot]    = r.next_hop;
          rt_stamp[slot]  = insert_seq;
          insert_seq      = insert_seq + 1;
          o.status        = ST_OK;
        end
      end
      FUNC_LOOKUP: begin
        n_lookup++;
        for (int i = 0; i < ENTRIES; i++) begin
          if (rt_valid[i] && rt_len[i] != 0 &&
              ((r.address ^ rt_prefix[i]) & prefix_mask(rt_len[i])) == 0) begin
            if (slot < 0 || rt_len[i] > rt_len[slot] ||
                (rt_len[i] == rt_len[slot] && rt_stamp[i] > rt_stamp[slot])) slot = i;
          end
        end
        if (slot >= 0) begin
          o.status         = ST_OK;
          o.iface_tag      = rt_tag[slot];
          o.next_hop       = rt_hop[slot];
          o.matched_length = rt_len[slot];
          n_hit++;
        end
      end
      FUNC_DELETE: begin
        n_delete++;
        for (int i = 0; i < ENTRIES; i++) begin
          if (rt_valid[i] && rt_prefix[i] == r.address && rt_len[i] == len) begin
            if (slot < 0 || rt_stamp[i] > rt_stamp[slot]) slot = i;
          end
        end
        if (slot >= 0) begin
          rt_valid[slot] = 1'b0;
          o.status = ST_OK;
          n_removed++;
        end
      end
      default: n_unused++;
    endcase
    return o;
  endfunction

  // one request on the req channel; bursts separated by random gaps
  task automatic send_request(input route_req_t r);
    int gap;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 140);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    req_ch.valid         <= 1'b1;
    req_ch.func          <= r.func;
    req_ch.address       <= r.address;
    req_ch.prefix_length <= r.prefix_length;
    req_ch.iface_tag     <= r.iface_tag;
    req_ch.next_hop_in   <= r.next_hop;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_rsp_q.push_back(apply_route_op(r));
    requests_sent++;
    @(negedge clk);
    burst_left--;
  endtask

  function automatic void check_field(input string what, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
    end
  endfunction

  task automatic test_empty_table();
    send_request(make_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00, 32'h0));
    send_request(make_request(FUNC_DELETE, 32'h0, 6'd0, 8'h00, 32'h0));
  endtask

  // nesting, saturated lengths, zero-length routes
  task automatic test_length_rules();
    send_request(make_request(FUNC_INSERT, 32'h0A00_0000, 6'd8, 8'h01, 32'hC0A8_0001));
    send_request(make_request(FUNC_INSERT, 32'h0A01_0000, 6'd16, 8'h02, 32'hC0A8_0002));
    send_request(make_request(FUNC_INSERT, 32'hFFFF_FFFF, 6'd63, 8'hFF, 32'hFFFF_FFFF));
    send_request(make_request(FUNC_INSERT, 32'h0, 6'd0, 8'h55, 32'h0));
    send_request(make_request(FUNC_LOOKUP, 32'h0A01_0203, 6'd0, 8'h00, 32'h0));
    send_request(make_request(FUNC_LOOKUP, 32'h0AC8_0001, 6'd0, 8'h00, 32'h0));
    send_request(make_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00, 32'h0));
    send_request(make_request(FUNC_LOOKUP, 32'h7FFF_FFFF, 6'd0, 8'h00, 32'h0));
    send_request(make_request(FUNC_LOOKUP, 32'h0, 6'd0, 8'h00, 32'h0));
    send_request(make_request(FUNC_DELETE, 32'hFFFF_FFFF, 6'd33, 8'h00, 32'h0));
    send_request(make_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00, 32'h0));
    send_request(make_request(FUNC_DELETE, 32'h0, 6'd0, 8'h00, 32'h0));
  endtask

  // equal lengths: newest insert wins lookup and is removed first
  task automatic test_newest_wins();
    send_request(make_request(FUNC_INSERT, 32'h8000_0000, 6'd1, 8'hA0, 32'h0101_0101));
    send_request(make_request(FUNC_INSERT, 32'h8000_0001, 6'd1, 8'hB0, 32'h0202_0202));
    send_request(make_request(FUNC_LOOKUP, 32'hC000_0000, 6'd0, 8'h00, 32'h0));
    send_request(make_request(FUNC_DELETE, 32'h8000_0001, 6'd1, 8'h00, 32'h0));
    send_request(make_request(FUNC_LOOKUP, 32'hC000_0000, 6'd0, 8'h00, 32'h0));
    send_request(make_request(FUNC_DELETE, 32'h8000_0000, 6'd2, 8'h00, 32'h0));
    send_request(make_request(FUNC_INSERT, 32'h8000_0000, 6'd1, 8'hC0, 32'h0303_0303));
    send_request(make_request(FUNC_DELETE, 32'h8000_0000, 6'd1, 8'h00, 32'h0));
    send_request(make_request(FUNC_LOOKUP, 32'hC000_0000, 6'd0, 8'h00, 32'h0));
  endtask

  task automatic test_unused_code();
    send_request(make_request(FUNC_UNUSED, 32'hFFFF_FFFF, 6'd63, 8'hFF, 32'hFFFF_FFFF));
    send_request(make_request(FUNC_UNUSED, 32'h0, 6'd0, 8'h00, 32'h0));
  endtask

  // overfill, then drain most of the table back out
  task automatic test_table_capacity();
    int slot;
    for (int i = 0; i < ENTRIES + 3; i++) begin
      send_request(pool_request(FUNC_INSERT, $urandom_range(0, POOL_SIZE - 1)));
    end
    repeat (ENTRIES - 12) begin
      slot = find_live_slot($urandom_range(0, ENTRIES - 1));
      if (slot >= 0) begin
        send_request(make_request(FUNC_DELETE, rt_prefix[slot], rt_len[slot], 8'h00, 32'h0));
      end
    end
  endtask

  // phases: fill-heavy, drain-heavy, mixed; mostly pool routes plus noise
  task automatic test_random_traffic();
    int phase_left, phase_kind, pick, ins_t, look_t, del_t, k, slot;
    logic [ADDR_BITS-1:0] m;
    route_req_t r;
    phase_left = 0;
    phase_kind = 0;
    while (requests_sent < TARGET_REQUESTS) begin
      if (phase_left == 0) begin
        phase_kind = $urandom_range(0, 2);
        phase_left = $urandom_range(40, 120);
      end
      phase_left--;
      case (phase_kind)
        0: begin ins_t = 60; look_t = 90; del_t = 95; end
        1: begin ins_t = 8;  look_t = 40; del_t = 95; end
        default: begin ins_t = 30; look_t = 75; del_t = 95; end
      endcase
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, POOL_SIZE - 1);
      if (pick < ins_t) begin
        if ($urandom_range(0, 9) == 0) begin
          r = make_request(FUNC_INSERT, $urandom, 6'($urandom_range(0, 32)), 8'($urandom),
                           $urandom);
        end else begin
          r = pool_request(FUNC_INSERT, k);
        end
      end else if (pick < look_t) begin
        m = prefix_mask(limit_len(pool_len[k]));
        case ($urandom_range(0, 9))
          0: r = make_request(FUNC_LOOKUP, $urandom, 6'($urandom), 8'($urandom), $urandom);
          1: r = make_request(FUNC_LOOKUP, pool_addr[k], 6'd0, 8'h00, 32'h0);
          default: r = make_request(FUNC_LOOKUP, (pool_addr[k] & m) | ($urandom & ~m),
                                    6'($urandom), 8'($urandom), $urandom);
        endcase
      end else if (pick < del_t) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            slot = find_live_slot($urandom_range(0, ENTRIES - 1));
            if (slot >= 0) r = make_request(FUNC_DELETE, rt_prefix[slot], rt_len[slot],
                                            8'($urandom), $urandom);
            else r = pool_request(FUNC_DELETE, k);
          end
          3: r = make_request(FUNC_DELETE, pool_addr[k] ^ (32'h1 << $urandom_range(0, 31)),
                              pool_len[k], 8'h00, 32'h0);
          4: r = make_request(FUNC_DELETE, pool_addr[k], limit_len(pool_len[k]) + 6'd1,
                              8'h00, 32'h0);
          default: r = pool_request(FUNC_DELETE, k);
        endcase
      end else begin
        r = make_request(2'($urandom_range(0, 3)), $urandom, 6'($urandom_range(0, 63)),
                         8'($urandom), $urandom);
      end
      send_request(r);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // response side: stall pattern changes mode after each random-length segment
  always @(negedge clk) begin
    if (sink_seg == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_seg  = $urandom_range(100, 600);
    end else begin
      sink_seg--;
    end
    if (sink_hold == 0) begin
      case (sink_mode)
        0: sink_rdy = 1'b1;
        1: sink_rdy = ($urandom_range(0, 3) != 0);
        2: begin
          sink_rdy  = !sink_rdy;
          sink_hold = $urandom_range(0, 3);
        end
        default: begin
          sink_rdy  = !sink_rdy;
          sink_hold = sink_rdy ? $urandom_range(0, 4) : $urandom_range(20, 150);
        end
      endcase
    end else begin
      sink_hold--;
    end
    rsp_ch.ready <= sink_rdy;
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        $display("%0t: response with none expected: status %0d", $time, rsp_ch.status);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        check_field("status", 32'(exp_rsp.status), 32'(rsp_ch.status));
        check_field("out_iface_tag", 32'(exp_rsp.iface_tag), 32'(rsp_ch.out_iface_tag));
        check_field("next_hop_out", exp_rsp.next_hop, rsp_ch.next_hop_out);
        check_field("matched_length", 32'(exp_rsp.matched_length),
                    32'(rsp_ch.matched_length));
      end
    end
  end

  // watchdog: cycles with no request or response accepted
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d responses outstanding", $time,
               idle_cycles, expected_rsp_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ADDR_BITS-1:0] bases[4];
    logic [ADDR_BITS-1:0] m;
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.func          = FUNC_INSERT;
    req_ch.address       = '0;
    req_ch.prefix_length = '0;
    req_ch.iface_tag     = '0;
    req_ch.next_hop_in   = '0;
    insert_seq           = '0;
    for (int i = 0; i < ENTRIES; i++) rt_valid[i] = 1'b0;

    // route pool: four bases, two of them siblings, lengths nested under each
    for (int i = 0; i < 4; i++) bases[i] = $urandom;
    bases[1] = bases[0] ^ 32'h0010_0000;
    for (int k = 0; k < POOL_SIZE; k++) begin
      case ($urandom_range(0, 9))
        0: pool_len[k] = 6'd0;
        1: pool_len[k] = 6'd8;
        2: pool_len[k] = 6'd16;
        3: pool_len[k] = 6'd24;
        4: pool_len[k] = 6'd32;
        5: pool_len[k] = 6'($urandom_range(33, 63));
        default: pool_len[k] = 6'($urandom_range(1, 32));
      endcase
      m = prefix_mask(limit_len(pool_len[k]));
      pool_addr[k] = bases[k % 4] & m;
      if ($urandom_range(0, 3) == 0) pool_addr[k] = pool_addr[k] | ($urandom & ~m);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_length_rules();
    test_newest_wins();
    test_unused_code();
    test_table_capacity();
    test_random_traffic();

    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (2 * (ENTRIES + 3)) @(posedge clk);

    $display("covered %0d requests: %0d inserts (%0d refused full), %0d lookups (%0d hits)",
             requests_sent, n_insert, n_full, n_lookup, n_hit);
    $display("  %0d deletes (%0d removed), %0d unused-code requests, %0d mismatches",
             n_delete, n_removed, n_unused, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* longest_prefix_route_table_top.f */
hdl/lprt_pkg.sv
hdl/lprt_if.sv
hdl/lprt_mem.sv
hdl/lprt_ctrl.sv
hdl/longest_prefix_route_table_top.sv
verif/tb_top.sv
